>>> rtl/core/rss_pkg.sv
// Shared constants for the rotated sorted search unit.
`timescale 1ns / 1ps

package rss_pkg;

    localparam int DEPTH_DEFAULT = 4096;
    localparam int WIDTH_DEFAULT = 16;

    localparam int INDEX_W = 12;
    localparam int VALUE_W = 16;
    localparam int LEN_W   = 13;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    // Register index of array_length, decoded from paddr[2].
    localparam logic REG_ARRAY_LENGTH = 1'b0;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

endpackage

>>> rtl/core/rss_channels.sv
// Valid/ready channel interfaces for the search requests and the search results.
`timescale 1ns / 1ps

interface rss_in_if
    import rss_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic        [INDEX_W-1:0] index;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

interface rss_out_if
    import rss_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               found;
    logic [INDEX_W-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

>>> rtl/core/rotated_sorted_search_unit.sv
// A write transaction is accepted while idle; a search runs as a sequence of probes.
// A probe reads the middle and left words, then compares them, and reads the right word for a
// second compare when the left half is not sorted; at most ceil(log2(N+1)) probes are made.
// One search is in flight at a time; a finished result waits in the output register.
// Reset: array_length returns to 1 and the FSM to idle; the element store is not cleared.
`timescale 1ns / 1ps

module rotated_sorted_search_unit
    import rss_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int WIDTH = WIDTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    rss_in_if.sink             in_ch,
    rss_out_if.source          out_ch
);

    // AW addresses the store, NW holds the clamped length, LW is signed so that
    // hi can reach -1 and lo can pass the last entry.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = (DEPTH > 1) ? $clog2(DEPTH + 1) : 1;
    localparam int LW = NW + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_CMPR,
        ST_DONE
    } state_t;

    // The element store: one write port and two synchronous read ports.
    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    rd_a_addr;
    logic [AW-1:0]    rd_b_addr;
    logic [WIDTH-1:0] rd_a_data;
    logic [WIDTH-1:0] rd_b_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WIDTH-1:0] wr_data;

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         array_length_reg;
    logic [NW-1:0]            n_reg, n_next;
    logic signed [LW-1:0]     lo_reg, lo_next;
    logic signed [LW-1:0]     hi_reg, hi_next;
    logic signed [LW-1:0]     mid_reg, mid_next;
    logic signed [WIDTH-1:0]  target_reg, target_next;
    logic                     res_found_reg, res_found_next;
    logic [INDEX_W-1:0]       res_position_reg, res_position_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_found_reg, out_found_next;
    logic [INDEX_W-1:0]       out_position_reg, out_position_next;

    logic                     in_take;
    logic                     cfg_write;
    logic signed [63:0]       value_ext;
    logic signed [WIDTH-1:0]  word_in;
    logic signed [LW-1:0]     mid_calc;
    logic signed [LW-1:0]     span;
    logic signed [WIDTH-1:0]  m_word;
    logic signed [WIDTH-1:0]  l_word;
    logic signed [WIDTH-1:0]  r_word;
    logic                     out_slot_free;

    // The input value is sign-extended and then cut to the stored word width,
    // the same for a stored element and for a search target.
    assign value_ext = 64'(in_ch.value);
    assign word_in   = value_ext[WIDTH-1:0];

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.found    = out_found_reg;
    assign out_ch.position = out_position_reg;
    assign out_slot_free   = !out_valid_reg || out_ch.ready;

    // Configuration port: array_length is the only register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ARRAY_LENGTH);
    assign prdata    = (paddr[2] == REG_ARRAY_LENGTH) ? PDATA_W'(array_length_reg) : '0;

    // Writes happen only while idle, so a search never reads a word that is being written.
    assign wr_en   = in_take && (in_ch.mode == MODE_WRITE) && (32'(in_ch.index) < 32'(DEPTH));
    assign wr_addr = AW'(in_ch.index);
    assign wr_data = word_in;

    // Midpoint of the current window; hi >= lo whenever it is used.
    assign span     = hi_reg - lo_reg;
    assign mid_calc = lo_reg + (span >>> 1);

    // Port A reads the middle word, port B the left word or, for an unsorted left
    // half, the right word.
    assign rd_a_addr = (state_reg == ST_PROBE) ? mid_calc[AW-1:0] : mid_reg[AW-1:0];
    assign rd_b_addr = (state_reg == ST_CMP) ? hi_reg[AW-1:0] : lo_reg[AW-1:0];

    assign m_word = rd_a_data;
    assign l_word = rd_b_data;
    assign r_word = rd_b_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

    always_comb
    begin
        state_next        = state_reg;
        n_next            = n_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mid_next          = mid_reg;
        target_next       = target_reg;
        res_found_next    = res_found_reg;
        res_position_next = res_position_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_found_next    = out_found_reg;
        out_position_next = out_position_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (in_ch.mode == MODE_SEARCH))
                begin
                    // Lengths above the store depth are clamped to the depth.
                    if (32'(array_length_reg) > 32'(DEPTH))
                    begin
                        n_next = NW'(DEPTH);
                    end
                    else
                    begin
                        n_next = NW'(array_length_reg);
                    end
                    lo_next     = '0;
                    hi_next     = $signed({1'b0, n_next}) - LW'(1);
                    target_next = word_in;
                    state_next  = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (lo_reg > hi_reg)
                begin
                    // Window is empty, which also covers a length of zero.
                    res_found_next    = 1'b0;
                    res_position_next = '0;
                    state_next        = ST_DONE;
                end
                else
                begin
                    mid_next   = mid_calc;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (m_word == target_reg)
                begin
                    res_found_next    = 1'b1;
                    res_position_next = INDEX_W'(mid_reg);
                    state_next        = ST_DONE;
                end
                else if (l_word <= m_word)
                begin
                    // Left half is sorted: keep it only if it brackets the target.
                    if ((target_reg >= l_word) && (target_reg < m_word))
                    begin
                        hi_next = mid_reg - LW'(1);
                    end
                    else
                    begin
                        lo_next = mid_reg + LW'(1);
                    end
                    state_next = ST_PROBE;
                end
                else
                begin
                    // Right half is sorted; its upper end is read next.
                    state_next = ST_CMPR;
                end
            end
            ST_CMPR:
            begin
                if ((target_reg > m_word) && (target_reg <= r_word))
                begin
                    lo_next = mid_reg + LW'(1);
                end
                else
                begin
                    hi_next = mid_reg - LW'(1);
                end
                state_next = ST_PROBE;
            end
            ST_DONE:
            begin
                // The answer moves to the output register only once the previous
                // transaction there has been taken.
                if (out_slot_free)
                begin
                    out_valid_next    = 1'b1;
                    out_found_next    = res_found_reg;
                    out_position_next = res_position_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            array_length_reg <= LEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                array_length_reg <= pwdata[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg            <= n_next;
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        mid_reg          <= mid_next;
        target_reg       <= target_next;
        res_found_reg    <= res_found_next;
        res_position_reg <= res_position_next;
        out_found_reg    <= out_found_next;
        out_position_reg <= out_position_next;
    end

`ifndef SYNTHESIS
    // A search holds off further transactions until its result is registered.
    a_search_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (in_ch.mode == MODE_SEARCH)) |=> !in_ch.ready)
        else $error("input accepted while a search is in progress");

    // The probe index always lies inside the current window.
    a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> ((mid_reg >= lo_reg) && (mid_reg <= hi_reg)))
        else $error("probe index outside the search window");

    // The upper bound never points past the clamped length.
    a_hi_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CMP) || (state_reg == ST_CMPR))
            |-> (hi_reg < $signed({1'b0, n_reg})))
        else $error("upper bound beyond the searched length");

    // A not-found result carries a zero position.
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_position_reg == '0))
        else $error("not-found result with a nonzero position");
`endif

endmodule
